### rtl/sec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sec_pkg
// Shared types and constants of the SHA-256 entropy conditioner.
// ----------------------------------------------------------------------------
package sec_pkg;

  localparam logic [255:0] IV_WORDS = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Chaining value sources for the compression unit
  localparam logic [1:0] HSEL_SEED = 2'd0;
  localparam logic [1:0] HSEL_IV   = 2'd1;
  localparam logic [1:0] HSEL_CHK  = 2'd2;

  typedef struct packed {
    logic       acc;
    logic       seed_pad;
    logic       seed_len_wr;
    logic       seed_hstore;
    logic       seed_fin;
    logic       w_load;
    logic       w_shift;
    logic       start;
    logic [1:0] hsel;
    logic       p_clr;
    logic       p_inc;
    logic       chk_store;
    logic       emit_load;
    logic       chunk_done;
  } sec_cmd_t;

  typedef struct packed {
    logic present;
    logic seed_pos63;
    logic fill_is31;
    logic seed_over;
    logic p_end;
    logic two_blocks;
    logic emit_end;
    logic out_free;
    logic core_done;
  } sec_status_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

### rtl/sec_compress.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sec_compress
// Iterative SHA-256 compression: one round per cycle, rolling schedule.
// ----------------------------------------------------------------------------
module sec_compress (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         w_load,
  input  wire logic [511:0] w_blk,
  input  wire logic         w_shift,
  input  wire logic [7:0]   w_byte,
  input  wire logic         start,
  input  wire logic [255:0] h_in,
  output logic              done,
  output logic [255:0]      digest
);

  logic [511:0] w;
  logic [31:0]  va, vb, vc, vd, ve, vf, vg, vh;
  logic [5:0]   rnd;
  logic         busy;

  logic [31:0] s1, chf, t1, s0, mj, t2, w1, w9, w14, ws0, ws1, wnew;

  always_comb begin
    s1   = sec_pkg::rotr(ve, 6) ^ sec_pkg::rotr(ve, 11) ^ sec_pkg::rotr(ve, 25);
    chf  = (ve & vf) ^ (~ve & vg);
    t1   = vh + s1 + chf + sec_pkg::K_TAB[rnd] + w[511:480];
    s0   = sec_pkg::rotr(va, 2) ^ sec_pkg::rotr(va, 13) ^ sec_pkg::rotr(va, 22);
    mj   = (va & vb) ^ (va & vc) ^ (vb & vc);
    t2   = s0 + mj;
    w1   = w[479:448];
    w9   = w[223:192];
    w14  = w[63:32];
    ws0  = sec_pkg::rotr(w1, 7) ^ sec_pkg::rotr(w1, 18) ^ (w1 >> 3);
    ws1  = sec_pkg::rotr(w14, 17) ^ sec_pkg::rotr(w14, 19) ^ (w14 >> 10);
    wnew = w[511:480] + ws0 + w9 + ws1;
  end

  assign digest = {va + h_in[255:224], vb + h_in[223:192], vc + h_in[191:160],
                   vd + h_in[159:128], ve + h_in[127:96],  vf + h_in[95:64],
                   vg + h_in[63:32],   vh + h_in[31:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      {va, vb, vc, vd, ve, vf, vg, vh} <= h_in;
    end else if (busy) begin
      vh <= vg;
      vg <= vf;
      vf <= ve;
      ve <= vd + t1;
      vd <= vc;
      vc <= vb;
      vb <= va;
      va <= t1 + t2;
    end
    if (w_load) begin
      w <= w_blk;
    end else if (w_shift) begin
      w <= {w[503:0], w_byte};
    end else if (busy) begin
      w <= {w[479:0], wnew};
    end
  end

endmodule
`default_nettype wire

### rtl/sec_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sec_dp
// Datapath: pool, seed message block, chunk store, message builder, output.
// ----------------------------------------------------------------------------
module sec_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sec_pkg::sec_cmd_t     cmd,
  output sec_pkg::sec_status_t       status,
  input  wire logic                  kind,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  last_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_last
);

  logic [255:0] pool;
  logic         present;
  logic [63:0]  seed_len;
  logic [511:0] seed_blk;
  logic [511:0] seed_blk_next;
  logic [255:0] h_seed;
  logic [255:0] h_chk;
  logic [7:0]   chunk_mem [32];
  logic [7:0]   mem_q;
  logic [5:0]   fill;
  logic [31:0]  counter;
  logic [6:0]   p;
  logic         chunk_last;

  logic [255:0] h_in;
  logic [255:0] digest;
  logic         core_done;
  logic [5:0]   pos6;
  logic [63:0]  total;
  logic [63:0]  bits;
  logic         seed_acc;
  logic         chunk_acc;
  logic         pass_acc;
  logic [6:0]   c_end;
  logic [6:0]   l_end;
  logic [6:0]   last_pos;
  logic [9:0]   lbits;
  logic [1:0]   cbyte;
  logic [7:0]   msg_byte;
  logic         two;
  logic         emit_end;
  logic         out_free;

  assign seed_acc  = cmd.acc && !kind;
  assign chunk_acc = cmd.acc && kind && present;
  assign pass_acc  = cmd.acc && kind && !present;

  // byte position of the next seed byte, or of the pad byte after the last one
  assign pos6  = {~seed_len[5], seed_len[4:0]};
  assign total = seed_len + 64'd32;
  assign bits  = {total[60:0], 3'b000};

  always_comb begin
    seed_blk_next = seed_blk;
    if (seed_acc) begin
      if (seed_len == 64'd0) begin
        for (int i = 0; i < 32; i++) begin
          seed_blk_next[511 - 8*i -: 8] = pool[8*i +: 8];
        end
      end
      for (int q = 0; q < 64; q++) begin
        if (6'(q) == pos6) seed_blk_next[511 - 8*q -: 8] = data_byte;
      end
    end
    if (cmd.seed_pad) begin
      for (int q = 0; q < 64; q++) begin
        if (6'(q) == pos6) begin
          seed_blk_next[511 - 8*q -: 8] = 8'h80;
        end else if (6'(q) > pos6) begin
          seed_blk_next[511 - 8*q -: 8] = 8'h00;
        end
      end
      if (pos6 < 6'd56) seed_blk_next[63:0] = bits;
    end
    if (cmd.seed_len_wr) begin
      seed_blk_next = {448'b0, bits};
    end
  end

  always_comb begin
    case (cmd.hsel)
      sec_pkg::HSEL_SEED: h_in = h_seed;
      sec_pkg::HSEL_IV:   h_in = sec_pkg::IV_WORDS;
      sec_pkg::HSEL_CHK:  h_in = h_chk;
      default:            h_in = sec_pkg::IV_WORDS;
    endcase
  end

  // Message for a chunk: pool, chunk bytes, counter, pad, bit length
  assign two      = fill > 6'd19;
  assign c_end    = 7'd32 + {1'b0, fill};
  assign l_end    = c_end + 7'd4;
  assign last_pos = two ? 7'd127 : 7'd63;
  assign lbits    = {l_end, 3'b000};
  assign cbyte    = p[1:0] - fill[1:0];

  always_comb begin
    if (p < 7'd32) begin
      msg_byte = pool[{p[4:0], 3'b000} +: 8];
    end else if (p < c_end) begin
      msg_byte = mem_q;
    end else if (p < l_end) begin
      msg_byte = counter[{cbyte, 3'b000} +: 8];
    end else if (p == l_end) begin
      msg_byte = 8'h80;
    end else if (p == last_pos) begin
      msg_byte = lbits[7:0];
    end else if (p == last_pos - 7'd1) begin
      msg_byte = {6'b0, lbits[9:8]};
    end else begin
      msg_byte = 8'h00;
    end
  end

  sec_compress u_compress (
    .clk     (clk),
    .rst     (rst),
    .w_load  (cmd.w_load),
    .w_blk   (seed_blk),
    .w_shift (cmd.w_shift),
    .w_byte  (msg_byte),
    .start   (cmd.start),
    .h_in    (h_in),
    .done    (core_done),
    .digest  (digest)
  );

  assign emit_end = p[4:0] == 5'(fill - 6'd1);
  assign out_free = !out_valid || out_ready;

  assign status.present    = present;
  assign status.seed_pos63 = seed_len[5:0] == 6'd31;
  assign status.fill_is31  = fill == 6'd31;
  assign status.seed_over  = pos6 >= 6'd56;
  assign status.p_end      = p[5:0] == 6'd63;
  assign status.two_blocks = two;
  assign status.emit_end   = emit_end;
  assign status.out_free   = out_free;
  assign status.core_done  = core_done;

  // chunk store: one write port, registered read one position ahead
  always_ff @(posedge clk) begin
    if (chunk_acc) chunk_mem[fill[4:0]] <= data_byte;
    mem_q <= chunk_mem[5'(p[4:0] + 5'd1)];
  end

  always_ff @(posedge clk) begin
    seed_blk <= seed_blk_next;
    if (cmd.chk_store) h_chk <= digest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool       <= '0;
      present    <= 1'b0;
      seed_len   <= '0;
      h_seed     <= sec_pkg::IV_WORDS;
      fill       <= '0;
      counter    <= '0;
      p          <= '0;
      chunk_last <= 1'b0;
      out_valid  <= 1'b0;
      out_byte   <= '0;
      out_last   <= 1'b0;
    end else begin
      if (seed_acc) begin
        seed_len <= seed_len + 64'd1;
        if (seed_len == 64'd0) h_seed <= sec_pkg::IV_WORDS;
      end
      if (cmd.seed_hstore) h_seed <= digest;
      if (cmd.seed_fin) begin
        for (int i = 0; i < 32; i++) begin
          pool[8*i +: 8] <= digest[255 - 8*i -: 8];
        end
        present  <= 1'b1;
        h_seed   <= sec_pkg::IV_WORDS;
        seed_len <= '0;
      end

      if (chunk_acc) begin
        fill       <= fill + 6'd1;
        chunk_last <= last_byte;
      end

      if (cmd.p_clr) begin
        p <= '0;
      end else if (cmd.p_inc || cmd.emit_load) begin
        p <= p + 7'd1;
      end

      if (pass_acc) begin
        out_valid <= 1'b1;
        out_byte  <= data_byte;
        out_last  <= last_byte;
        if (last_byte) counter <= '0;
      end else if (cmd.emit_load) begin
        out_valid <= 1'b1;
        out_byte  <= h_chk[{~p[4:0], 3'b000} +: 8];
        out_last  <= chunk_last && emit_end;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.chunk_done) begin
        fill    <= '0;
        counter <= chunk_last ? 32'd0 : counter + 32'd1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/sec_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sec_ctrl
// Controller: sequences seed absorption, chunk hashing and byte emission.
// ----------------------------------------------------------------------------
module sec_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 kind,
  input  wire logic                 last_byte,
  input  wire sec_pkg::sec_status_t status,
  output sec_pkg::sec_cmd_t         cmd
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SEED_GO   = 4'd1;
  localparam logic [3:0] ST_SEED_WAIT = 4'd2;
  localparam logic [3:0] ST_SEED_PAD  = 4'd3;
  localparam logic [3:0] ST_SEED_LEN  = 4'd4;
  localparam logic [3:0] ST_CH_LOAD   = 4'd5;
  localparam logic [3:0] ST_CH_GO     = 4'd6;
  localparam logic [3:0] ST_CH_WAIT   = 4'd7;
  localparam logic [3:0] ST_EMIT      = 4'd8;

  localparam logic [1:0] PH_DATA  = 2'd0;
  localparam logic [1:0] PH_OVER  = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  logic [3:0] state, state_next;
  logic [1:0] ph, ph_next;
  logic       blk2, blk2_next;
  logic       seed_last, seed_last_next;
  logic       acc;

  assign in_ready = (state == ST_IDLE) && status.out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    ph_next        = ph;
    blk2_next      = blk2;
    seed_last_next = seed_last;
    cmd            = '0;
    cmd.hsel       = sec_pkg::HSEL_SEED;
    case (state)
      ST_IDLE: begin
        cmd.acc = acc;
        if (acc) begin
          if (!kind) begin
            seed_last_next = last_byte;
            if (status.seed_pos63) begin
              ph_next    = PH_DATA;
              state_next = ST_SEED_GO;
            end else if (last_byte) begin
              state_next = ST_SEED_PAD;
            end
          end else if (status.present && (status.fill_is31 || last_byte)) begin
            blk2_next  = 1'b0;
            cmd.p_clr  = 1'b1;
            state_next = ST_CH_LOAD;
          end
        end
      end
      ST_SEED_GO: begin
        cmd.w_load = 1'b1;
        cmd.start  = 1'b1;
        state_next = ST_SEED_WAIT;
      end
      ST_SEED_WAIT: begin
        if (status.core_done) begin
          case (ph)
            PH_DATA: begin
              cmd.seed_hstore = 1'b1;
              state_next      = seed_last ? ST_SEED_PAD : ST_IDLE;
            end
            PH_OVER: begin
              cmd.seed_hstore = 1'b1;
              state_next      = ST_SEED_LEN;
            end
            default: begin
              cmd.seed_fin = 1'b1;
              state_next   = ST_IDLE;
            end
          endcase
        end
      end
      ST_SEED_PAD: begin
        cmd.seed_pad = 1'b1;
        ph_next      = status.seed_over ? PH_OVER : PH_FINAL;
        state_next   = ST_SEED_GO;
      end
      ST_SEED_LEN: begin
        cmd.seed_len_wr = 1'b1;
        ph_next         = PH_FINAL;
        state_next      = ST_SEED_GO;
      end
      ST_CH_LOAD: begin
        cmd.w_shift = 1'b1;
        cmd.p_inc   = 1'b1;
        if (status.p_end) state_next = ST_CH_GO;
      end
      ST_CH_GO: begin
        cmd.hsel   = blk2 ? sec_pkg::HSEL_CHK : sec_pkg::HSEL_IV;
        cmd.start  = 1'b1;
        state_next = ST_CH_WAIT;
      end
      ST_CH_WAIT: begin
        cmd.hsel = blk2 ? sec_pkg::HSEL_CHK : sec_pkg::HSEL_IV;
        if (status.core_done) begin
          cmd.chk_store = 1'b1;
          if (!blk2 && status.two_blocks) begin
            blk2_next  = 1'b1;
            state_next = ST_CH_LOAD;
          end else begin
            cmd.p_clr  = 1'b1;
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_end) begin
            cmd.chunk_done = 1'b1;
            state_next     = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ph        <= PH_DATA;
      blk2      <= 1'b0;
      seed_last <= 1'b0;
    end else begin
      state     <= state_next;
      ph        <= ph_next;
      blk2      <= blk2_next;
      seed_last <= seed_last_next;
    end
  end

endmodule
`default_nettype wire

### rtl/sha256_entropy_conditioner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_entropy_conditioner
// SHA-256 conditioning of raw random bytes against a seeded 256-bit pool.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid in_ready kind data_byte      | sink
//           | last_byte                             |
//   out     | out_valid out_ready out_byte out_last | source
//
// One item at a time. A seed byte that fills a block, or ends a seed, starts one
// or more compressions before the next input byte is taken. A completed chunk of
// n bytes is loaded byte by byte and compressed as one block for n up to 19, two
// above, then emitted as n output bytes.
// Hashing uses the single round-per-cycle compression unit.
// Reset is synchronous; output stalls hold the emit sequence in place.
// ----------------------------------------------------------------------------
module sha256_entropy_conditioner (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       kind,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  sec_pkg::sec_cmd_t    cmd;
  sec_pkg::sec_status_t status;

  sec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .last_byte (last_byte),
    .status    (status),
    .cmd       (cmd)
  );

  sec_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .kind      (kind),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire
